[rtl/core/epaf_pkg.sv]
// Shared types and constants for the ellipse pair affine fit datapath.
`timescale 1ns / 1ps

package epaf_pkg;

  // Fixed widths that follow from the 32-bit input and output fields.
  localparam int SHAPE_FRAC = 24;
  localparam int RAD_W      = 56;
  localparam int ROOT_W     = 28;
  localparam int QUOT_W     = 33;
  localparam int WIDE_W     = 66;

  typedef logic [31:0]        uword_t;
  typedef logic signed [31:0] sword_t;

  // Per-ellipse factor terms, filled in as the pipeline computes them.
  typedef struct packed {
    logic [31:0]        a;
    logic [31:0]        bmag;
    logic               b_neg;
    logic               bad;
    logic [ROOT_W-1:0]  l11;
    logic [ROOT_W-1:0]  q;
    logic [ROOT_W-1:0]  l00;
  } shape_t;

  // Context that travels beside the factorization units.
  typedef struct packed {
    shape_t s1;
    shape_t s2;
    sword_t x1;
    sword_t y1;
    sword_t x2;
    sword_t y2;
    logic   num_neg;
  } ctx_t;

  // Saturated matrix terms with the centres.
  typedef struct packed {
    sword_t hxx;
    sword_t hyx;
    sword_t hyy;
    sword_t x1;
    sword_t y1;
    sword_t x2;
    sword_t y2;
    logic   err;
    logic   bad;
  } mat_t;

  // Terms that wait beside the similarity divider.
  typedef struct packed {
    sword_t                    hxx;
    sword_t                    hyx;
    sword_t                    hyy;
    sword_t                    det;
    logic signed [WIDE_W-1:0]  tx_sum;
    logic signed [WIDE_W-1:0]  ty_sum;
    logic                      err;
    logic                      bad;
    logic                      flat;
  } post_t;

  // Final result fields.
  typedef struct packed {
    sword_t hxx;
    sword_t hyx;
    sword_t hyy;
    sword_t tx;
    sword_t ty;
    sword_t det;
    sword_t sim;
    logic   err;
    logic   bad;
    logic   flat;
  } res_t;

endpackage

[rtl/core/epaf_if.sv]
// Handshake channel interfaces for ellipse pairs and fit results.
`timescale 1ns / 1ps

interface epaf_pair_if;
  logic            valid;
  logic            ready;
  epaf_pkg::uword_t first_shape_a;
  epaf_pkg::sword_t first_shape_b;
  epaf_pkg::uword_t first_shape_c;
  epaf_pkg::sword_t first_center_x;
  epaf_pkg::sword_t first_center_y;
  epaf_pkg::uword_t second_shape_a;
  epaf_pkg::sword_t second_shape_b;
  epaf_pkg::uword_t second_shape_c;
  epaf_pkg::sword_t second_center_x;
  epaf_pkg::sword_t second_center_y;

  modport source (
    output valid, first_shape_a, first_shape_b, first_shape_c, first_center_x,
           first_center_y, second_shape_a, second_shape_b, second_shape_c,
           second_center_x, second_center_y,
    input  ready
  );
  modport sink (
    input  valid, first_shape_a, first_shape_b, first_shape_c, first_center_x,
           first_center_y, second_shape_a, second_shape_b, second_shape_c,
           second_center_x, second_center_y,
    output ready
  );
endinterface

interface epaf_fit_if;
  logic             valid;
  logic             ready;
  epaf_pkg::sword_t scale_xx;
  epaf_pkg::sword_t shear_yx;
  epaf_pkg::sword_t scale_yy;
  epaf_pkg::sword_t shift_x;
  epaf_pkg::sword_t shift_y;
  epaf_pkg::sword_t determinant;
  epaf_pkg::sword_t similarity;
  logic             fit_error;

  modport source (
    output valid, scale_xx, shear_yx, scale_yy, shift_x, shift_y, determinant,
           similarity, fit_error,
    input  ready
  );
  modport sink (
    input  valid, scale_xx, shear_yx, scale_yy, shift_x, shift_y, determinant,
           similarity, fit_error,
    output ready
  );
endinterface

[rtl/core/epaf_sqrt.sv]
// Pipelined truncated integer square root, one root bit per stage.
`timescale 1ns / 1ps

module epaf_sqrt #(
  parameter int IW = 56
) (
  input  logic            clk,
  input  logic            ce,
  input  logic [IW-1:0]   rad,
  output logic [IW/2-1:0] root
);

  localparam int RW = IW / 2;

  logic [IW-1:0] rad_q  [RW-1];
  logic [RW:0]   rem_q  [RW-1];
  logic [RW-1:0] root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [IW-1:0] in_rad;
    logic [RW:0]   in_rem;
    logic [RW-1:0] in_root;
    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign in_rad  = rad;
      assign in_rem  = '0;
      assign in_root = '0;
    end else begin : g_next
      assign in_rad  = rad_q[k-1];
      assign in_rem  = rem_q[k-1];
      assign in_root = root_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh = {in_rem, in_rad[IW-1 -: 2]};
    assign trial  = {1'b0, in_root, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (ce) begin
        root_q[k] <= {in_root[RW-2:0], ge};
      end
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          rad_q[k] <= in_rad << 2;
          rem_q[k] <= ge ? diff[RW:0] : rem_sh[RW:0];
        end
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

[rtl/core/epaf_div.sv]
// Pipelined restoring divider with an overflow check, one quotient bit per stage.
`timescale 1ns / 1ps

module epaf_div #(
  parameter int NW = 56,
  parameter int DW = 28,
  parameter int QW = 28
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int WW = (NW > DW + QW) ? NW : DW + QW;

  logic [WW-1:0] rem0;
  logic [DW-1:0] den0;
  logic          ovf0;
  logic [WW-1:0] rem_q [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] quo_q [QW];
  logic          ovf_q [QW];

  // The quotient overflows when it needs more than QW bits.
  always_ff @(posedge clk) begin
    if (ce) begin
      rem0 <= WW'(num);
      den0 <= den;
      ovf0 <= WW'(num) >= (WW'(den) << QW);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [WW-1:0] in_rem;
    logic [DW-1:0] in_den;
    logic [QW-1:0] in_quo;
    logic          in_ovf;
    logic [WW-1:0] ds;
    logic          ge;

    if (k == 0) begin : g_first
      assign in_rem = rem0;
      assign in_den = den0;
      assign in_quo = '0;
      assign in_ovf = ovf0;
    end else begin : g_next
      assign in_rem = rem_q[k-1];
      assign in_den = den_q[k-1];
      assign in_quo = quo_q[k-1];
      assign in_ovf = ovf_q[k-1];
    end

    // Subtract the divisor aligned to this quotient bit when it fits.
    assign ds = WW'(in_den) << (QW - 1 - k);
    assign ge = in_rem >= ds;

    always_ff @(posedge clk) begin
      if (ce) begin
        quo_q[k] <= {in_quo[QW-2:0], ge};
        ovf_q[k] <= in_ovf;
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_q[k] <= ge ? in_rem - ds : in_rem;
          den_q[k] <= in_den;
        end
      end
    end
  end

  assign quo = quo_q[QW-1];
  assign ovf = ovf_q[QW-1];

endmodule

[rtl/core/ellipse_pair_affine_fit.sv]
// Top level: affine map, determinant and similarity from a matched ellipse pair.
// Throughput is one pair per cycle unless the output stalls; every stage is
// registered and one bit of each square root or quotient is settled per stage,
// so the depth is set by those units.
// The whole pipeline advances together whenever the output register is empty or taken.
// Synchronous active-high reset clears the valid bits; data registers are not reset.
`timescale 1ns / 1ps

module ellipse_pair_affine_fit #(
  parameter int COORD_FRAC_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  epaf_pair_if.sink   pair,
  epaf_fit_if.source  fit
);

  localparam int F        = COORD_FRAC_BITS;
  localparam int RW       = epaf_pkg::ROOT_W;
  localparam int QW       = epaf_pkg::QUOT_W;
  localparam int SF       = epaf_pkg::SHAPE_FRAC;
  localparam int XW       = epaf_pkg::WIDE_W;
  localparam int SQRT_LAT = RW;
  localparam int QDIV_LAT = RW + 1;
  localparam int HDIV_LAT = QW + 1;
  localparam int LAT      = 2 * SQRT_LAT + QDIV_LAT + 2 * HDIV_LAT + 10;
  localparam int NMAG_W   = 2 * RW + 1;

  // Quotient to saturated signed term; returns the error flag above the value.
  function automatic logic [32:0] sat_quot(input logic [QW-1:0] q, input logic ovf,
                                           input logic neg);
    logic [QW:0]   sum;
    logic [QW-1:0] m;
    logic [32:0]   res;
    sum = {1'b0, q} + (QW+1)'(1);
    m   = sum[QW:1];
    if (neg) begin
      if (ovf || m > {1'b0, 32'h80000000}) res = {1'b1, 32'h80000000};
      else res = {1'b0, 32'(-m[31:0])};
    end else begin
      if (ovf || m > {1'b0, 32'h7FFFFFFF}) res = {1'b1, 32'h7FFFFFFF};
      else res = {1'b0, m[31:0]};
    end
    return res;
  endfunction

  // Drop F fraction bits, ties away from zero, then saturate to 32 bits.
  function automatic logic [32:0] rnd_sat(input logic signed [XW-1:0] v);
    logic [XW-1:0] mag;
    logic [XW-1:0] rm;
    logic [32:0]   res;
    mag = v[XW-1] ? XW'(-v) : XW'(v);
    rm  = (mag + (XW'(1) << (F - 1))) >> F;
    if (!v[XW-1]) begin
      if (rm > XW'(32'h7FFFFFFF)) res = {1'b1, 32'h7FFFFFFF};
      else res = {1'b0, rm[31:0]};
    end else begin
      if (rm > XW'(32'h80000000)) res = {1'b1, 32'h80000000};
      else res = {1'b0, 32'(-rm[31:0])};
    end
    return res;
  endfunction

  logic           ce;
  logic [LAT-1:0] vld;

  // Global advance: the output register is empty or being taken.
  assign ce         = !vld[LAT-1] || fit.ready;
  assign pair.ready = ce;
  assign fit.valid  = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], pair.valid};
    end
  end

  // Input transaction into context form.
  epaf_pkg::ctx_t c0;
  always_comb begin
    c0 = '0;
    c0.s1.a     = pair.first_shape_a;
    c0.s1.bmag  = pair.first_shape_b[31] ? 32'(-pair.first_shape_b)
                                         : 32'(pair.first_shape_b);
    c0.s1.b_neg = pair.first_shape_b[31];
    c0.s1.bad   = pair.first_shape_c == '0;
    c0.s2.a     = pair.second_shape_a;
    c0.s2.bmag  = pair.second_shape_b[31] ? 32'(-pair.second_shape_b)
                                          : 32'(pair.second_shape_b);
    c0.s2.b_neg = pair.second_shape_b[31];
    c0.s2.bad   = pair.second_shape_c == '0;
    c0.x1       = pair.first_center_x;
    c0.y1       = pair.first_center_y;
    c0.x2       = pair.second_center_x;
    c0.y2       = pair.second_center_y;
  end

  // l11 = sqrt(c) with 24 fraction bits.
  logic [RW-1:0] l11_1, l11_2;
  epaf_sqrt #(.IW(epaf_pkg::RAD_W)) u_sqrt_c1 (
    .clk(clk), .ce(ce), .rad({pair.first_shape_c, 24'd0}), .root(l11_1)
  );
  epaf_sqrt #(.IW(epaf_pkg::RAD_W)) u_sqrt_c2 (
    .clk(clk), .ce(ce), .rad({pair.second_shape_c, 24'd0}), .root(l11_2)
  );

  epaf_pkg::ctx_t d1 [SQRT_LAT];
  epaf_pkg::ctx_t c1;
  always_ff @(posedge clk) begin
    if (ce) begin
      d1[0] <= c0;
      for (int i = 1; i < SQRT_LAT; i++) d1[i] <= d1[i-1];
    end
  end
  always_comb begin
    c1        = d1[SQRT_LAT-1];
    c1.s1.l11 = l11_1;
    c1.s2.l11 = l11_2;
  end

  // l10 magnitude = |b| * 2^24 / l11; a quotient of 2^28 or more is rejected.
  logic [RW-1:0] q1, q2;
  logic          qovf1, qovf2;
  epaf_div #(.NW(32 + SF), .DW(RW), .QW(RW)) u_qdiv1 (
    .clk(clk), .ce(ce), .num({c1.s1.bmag, 24'd0}), .den(c1.s1.l11),
    .quo(q1), .ovf(qovf1)
  );
  epaf_div #(.NW(32 + SF), .DW(RW), .QW(RW)) u_qdiv2 (
    .clk(clk), .ce(ce), .num({c1.s2.bmag, 24'd0}), .den(c1.s2.l11),
    .quo(q2), .ovf(qovf2)
  );

  epaf_pkg::ctx_t d2 [QDIV_LAT];
  epaf_pkg::ctx_t c2;
  always_ff @(posedge clk) begin
    if (ce) begin
      d2[0] <= c1;
      for (int i = 1; i < QDIV_LAT; i++) d2[i] <= d2[i-1];
    end
  end
  always_comb begin
    c2        = d2[QDIV_LAT-1];
    c2.s1.q   = q1;
    c2.s2.q   = q2;
    c2.s1.bad = d2[QDIV_LAT-1].s1.bad | qovf1;
    c2.s2.bad = d2[QDIV_LAT-1].s2.bad | qovf2;
  end

  // Square the l10 terms.
  epaf_pkg::ctx_t      c3a;
  logic [2*RW-1:0]     sq1, sq2;
  always_ff @(posedge clk) begin
    if (ce) begin
      c3a <= c2;
      sq1 <= (2*RW)'(c2.s1.q) * (2*RW)'(c2.s1.q);
      sq2 <= (2*RW)'(c2.s2.q) * (2*RW)'(c2.s2.q);
    end
  end

  // a - l10^2 must stay positive.
  epaf_pkg::ctx_t  c3b, c3b_next;
  logic [2*RW-1:0] a48_1, a48_2, diff1, diff2;
  assign a48_1 = {c3a.s1.a, 24'd0};
  assign a48_2 = {c3a.s2.a, 24'd0};
  always_comb begin
    c3b_next        = c3a;
    c3b_next.s1.bad = c3a.s1.bad | (sq1 >= a48_1);
    c3b_next.s2.bad = c3a.s2.bad | (sq2 >= a48_2);
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      c3b   <= c3b_next;
      diff1 <= a48_1 - sq1;
      diff2 <= a48_2 - sq2;
    end
  end

  // l00 = sqrt(a - l10^2).
  logic [RW-1:0] l00_1, l00_2;
  epaf_sqrt #(.IW(epaf_pkg::RAD_W)) u_sqrt_a1 (
    .clk(clk), .ce(ce), .rad(diff1), .root(l00_1)
  );
  epaf_sqrt #(.IW(epaf_pkg::RAD_W)) u_sqrt_a2 (
    .clk(clk), .ce(ce), .rad(diff2), .root(l00_2)
  );

  epaf_pkg::ctx_t d3 [SQRT_LAT];
  epaf_pkg::ctx_t c3;
  always_ff @(posedge clk) begin
    if (ce) begin
      d3[0] <= c3b;
      for (int i = 1; i < SQRT_LAT; i++) d3[i] <= d3[i-1];
    end
  end
  always_comb begin
    c3        = d3[SQRT_LAT-1];
    c3.s1.l00 = l00_1;
    c3.s2.l00 = l00_2;
  end

  // Cross products for the shear numerator and its divisor.
  epaf_pkg::ctx_t  c4a;
  logic [2*RW-1:0] p1, p2, den_p;
  always_ff @(posedge clk) begin
    if (ce) begin
      c4a   <= c3;
      p1    <= (2*RW)'(c3.s1.q) * (2*RW)'(c3.s2.l00);
      p2    <= (2*RW)'(c3.s1.l00) * (2*RW)'(c3.s2.q);
      den_p <= (2*RW)'(c3.s2.l00) * (2*RW)'(c3.s2.l11);
    end
  end

  // Signed shear numerator k1*l00_2 - l00_1*k2 as magnitude and sign.
  logic signed [2*RW+1:0] sp1, sp2, nsum;
  epaf_pkg::ctx_t         c4b, c4b_next;
  logic [NMAG_W-1:0]      nmag;
  logic [2*RW-1:0]        den_r;
  assign sp1  = c4a.s1.b_neg ? -$signed({2'b00, p1}) : $signed({2'b00, p1});
  assign sp2  = c4a.s2.b_neg ? -$signed({2'b00, p2}) : $signed({2'b00, p2});
  assign nsum = sp1 - sp2;
  always_comb begin
    c4b_next         = c4a;
    c4b_next.num_neg = nsum[2*RW+1];
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      c4b   <= c4b_next;
      nmag  <= nsum[2*RW+1] ? NMAG_W'(-nsum) : nsum[NMAG_W-1:0];
      den_r <= den_p;
    end
  end

  // Matrix term quotients with one extra bit for rounding.
  logic [QW-1:0] qxx, qyx, qyy;
  logic          oxx, oyx, oyy;
  epaf_div #(.NW(RW + F + 1), .DW(RW), .QW(QW)) u_div_xx (
    .clk(clk), .ce(ce), .num({c4b.s1.l00, {(F+1){1'b0}}}), .den(c4b.s2.l00),
    .quo(qxx), .ovf(oxx)
  );
  epaf_div #(.NW(RW + F + 1), .DW(RW), .QW(QW)) u_div_yy (
    .clk(clk), .ce(ce), .num({c4b.s1.l11, {(F+1){1'b0}}}), .den(c4b.s2.l11),
    .quo(qyy), .ovf(oyy)
  );
  epaf_div #(.NW(NMAG_W + F + 1), .DW(2*RW), .QW(QW)) u_div_yx (
    .clk(clk), .ce(ce), .num({nmag, {(F+1){1'b0}}}), .den(den_r),
    .quo(qyx), .ovf(oyx)
  );

  epaf_pkg::ctx_t d4 [HDIV_LAT];
  always_ff @(posedge clk) begin
    if (ce) begin
      d4[0] <= c4b;
      for (int i = 1; i < HDIV_LAT; i++) d4[i] <= d4[i-1];
    end
  end

  // Round and saturate the matrix terms.
  epaf_pkg::ctx_t c5;
  logic [32:0]    rxx, ryx, ryy;
  epaf_pkg::mat_t m;
  assign c5  = d4[HDIV_LAT-1];
  assign rxx = sat_quot(qxx, oxx, 1'b0);
  assign ryy = sat_quot(qyy, oyy, 1'b0);
  assign ryx = sat_quot(qyx, oyx, c5.num_neg);
  always_ff @(posedge clk) begin
    if (ce) begin
      m.hxx <= rxx[31:0];
      m.hyx <= ryx[31:0];
      m.hyy <= ryy[31:0];
      m.x1  <= c5.x1;
      m.y1  <= c5.y1;
      m.x2  <= c5.x2;
      m.y2  <= c5.y2;
      m.err <= rxx[32] | ryx[32] | ryy[32];
      m.bad <= c5.s1.bad | c5.s2.bad;
    end
  end

  // Products for translation, determinant and the norm.
  epaf_pkg::mat_t     mx;
  logic signed [63:0] px, pyx, pyy, pdet;
  logic [31:0]        n1, n2, n3;
  logic [63:0]        n1sq, n2sq, n3sq, n13;
  assign n1 = 32'(m.hxx);
  assign n2 = m.hyx[31] ? 32'(-m.hyx) : 32'(m.hyx);
  assign n3 = 32'(m.hyy);
  always_ff @(posedge clk) begin
    if (ce) begin
      mx   <= m;
      px   <= 64'(m.hxx) * 64'(m.x1);
      pyx  <= 64'(m.hyx) * 64'(m.x1);
      pyy  <= 64'(m.hyy) * 64'(m.y1);
      pdet <= 64'(m.hxx) * 64'(m.hyy);
      n1sq <= 64'(n1) * 64'(n1);
      n2sq <= 64'(n2) * 64'(n2);
      n3sq <= 64'(n3) * 64'(n3);
      n13  <= 64'(n1) * 64'(n3);
    end
  end

  // Exact translation sums, rounded determinant, norm and similarity numerator.
  logic signed [XW-1:0] x2s, y2s;
  logic [32:0]          rdet;
  logic [63:0]          norm_c;
  epaf_pkg::post_t      ps;
  logic [63:0]          norm_r, numt_r;
  assign x2s    = XW'(mx.x2) <<< F;
  assign y2s    = XW'(mx.y2) <<< F;
  assign rdet   = rnd_sat(XW'(pdet));
  assign norm_c = n1sq + n2sq + n3sq;
  always_ff @(posedge clk) begin
    if (ce) begin
      ps.hxx    <= mx.hxx;
      ps.hyx    <= mx.hyx;
      ps.hyy    <= mx.hyy;
      ps.det    <= rdet[31:0];
      ps.tx_sum <= x2s - XW'(px);
      ps.ty_sum <= y2s - XW'(pyx) - XW'(pyy);
      ps.err    <= mx.err | rdet[32] | (norm_c == '0);
      ps.bad    <= mx.bad;
      ps.flat   <= norm_c == '0;
      norm_r    <= norm_c;
      numt_r    <= {n13[62:0], 1'b0};
    end
  end

  // t = 2*n1*n3 / norm with 31 fraction bits plus one rounding bit.
  logic [QW-1:0] qt;
  logic          ot;
  epaf_div #(.NW(96), .DW(64), .QW(QW)) u_div_t (
    .clk(clk), .ce(ce), .num({numt_r, 32'd0}), .den(norm_r), .quo(qt), .ovf(ot)
  );

  epaf_pkg::post_t d5 [HDIV_LAT];
  always_ff @(posedge clk) begin
    if (ce) begin
      d5[0] <= ps;
      for (int i = 1; i < HDIV_LAT; i++) d5[i] <= d5[i-1];
    end
  end

  // Round t and the translation terms.
  epaf_pkg::post_t p6;
  logic [QW:0]     tsum;
  logic [32:0]     rtx, rty;
  epaf_pkg::res_t  o1, o2;
  logic [31:0]     t_r;
  assign p6   = d5[HDIV_LAT-1];
  assign tsum = {1'b0, qt} + (QW+1)'(1);
  assign rtx  = rnd_sat(p6.tx_sum);
  assign rty  = rnd_sat(p6.ty_sum);
  always_ff @(posedge clk) begin
    if (ce) begin
      o1.hxx  <= p6.hxx;
      o1.hyx  <= p6.hyx;
      o1.hyy  <= p6.hyy;
      o1.tx   <= rtx[31:0];
      o1.ty   <= rty[31:0];
      o1.det  <= p6.det;
      o1.sim  <= '0;
      o1.err  <= p6.err | rtx[32] | rty[32] | ot;
      o1.bad  <= p6.bad;
      o1.flat <= p6.flat;
      t_r     <= tsum[32:1];
    end
  end

  // Square t.
  logic [63:0] tsq;
  always_ff @(posedge clk) begin
    if (ce) begin
      o2  <= o1;
      tsq <= 64'(t_r) * 64'(t_r);
    end
  end

  // Output register: similarity, and all-zero fields with the error flag set for a rejected form.
  logic [63:0]    sterm;
  epaf_pkg::res_t res, res_next;
  assign sterm = (tsq + (64'd1 << (61 - F))) >> (62 - F);
  always_comb begin
    if (o2.bad) begin
      res_next     = '0;
      res_next.err = 1'b1;
    end else begin
      res_next     = o2;
      res_next.sim = o2.flat ? '0 : 32'((64'd1 << F) - sterm);
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      res <= res_next;
    end
  end

  assign fit.scale_xx    = res.hxx;
  assign fit.shear_yx    = res.hyx;
  assign fit.scale_yy    = res.hyy;
  assign fit.shift_x     = res.tx;
  assign fit.shift_y     = res.ty;
  assign fit.determinant = res.det;
  assign fit.similarity  = res.sim;
  assign fit.fit_error   = res.err;

`ifndef SYNTHESIS
  // An empty output register always lets a new pair in.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !fit.valid |-> pair.ready)
    else $error("pair not accepted while output register is empty");

  // Similarity lies between zero and one.
  a_sim_range: assert property (@(posedge clk) disable iff (rst)
    fit.valid |-> ($unsigned(fit.similarity) <= (32'd1 << COORD_FRAC_BITS)))
    else $error("similarity out of range");

  // Diagonal terms and the determinant are never negative.
  a_diag_sign: assert property (@(posedge clk) disable iff (rst)
    fit.valid |-> (!fit.scale_xx[31] && !fit.scale_yy[31] && !fit.determinant[31]))
    else $error("negative diagonal term or determinant");
`endif

endmodule
